// ----- sv/pdcs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdcs_pkg: shared types and constants of the source capability selector
// Holds the PDO decode types, the queue entry layout, register codes and the
// fixed scaling constants used by the front and back parts.
// ----------------------------------------------------------------------------
package pdcs_pkg;

  // list and queue geometry
  localparam int unsigned MAX_PDOS    = 7;
  localparam int unsigned QUEUE_DEPTH = 2;   // power of two, pointers wrap

  // field widths
  localparam int unsigned VOLT_W  = 16;
  localparam int unsigned CURR_W  = 14;
  localparam int unsigned POS_W   = 3;
  localparam int unsigned VAL_W   = 10;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned PROD_W  = VOLT_W + CURR_W;
  localparam int unsigned IN_DATA_W  = 40;   // pdo_word, battery_percent, pad
  localparam int unsigned OUT_DATA_W = 56;   // found, request_object, voltage_mv, pad

  // unit scaling
  localparam logic [VOLT_W-1:0] VOLT_UNIT_MV = 16'd50;
  localparam logic [CURR_W-1:0] CURR_UNIT_MA = 14'd10;
  localparam logic [PCT_W-1:0]  FULL_PERCENT = 7'd100;
  localparam logic [VOLT_W-1:0] DEFAULT_VOLTAGE_MV = 16'd5000;
  localparam logic [31:0]       DEFAULT_RDO = 32'h1100_C832;  // pos 1, 50/50 x 10 mA

  // battery power limit: pdo units * 250 mW * 1000 per mW-product unit
  localparam logic [PROD_W:0] PWR_LIMIT_STEP = 31'd250000;
  localparam logic [PROD_W:0] MILLI          = 31'd1000;
  // floor(x / 15625) for x below 2^26, applied to product >> 4
  localparam logic [26:0]     PWR_RECIP = 27'd70368745;
  localparam int unsigned     PWR_SHIFT = 40;
  // floor(x / 10) for x below 2^14
  localparam logic [14:0]     CUR_RECIP = 15'd26215;
  localparam int unsigned     CUR_SHIFT = 18;

  // configuration register reset values
  localparam logic [VOLT_W-1:0] RST_CHARGE_V = 16'd9000;
  localparam logic [CURR_W-1:0] RST_CHARGE_I = 14'd2000;
  localparam logic [VOLT_W-1:0] RST_FULL_V   = 16'd5000;
  localparam logic [CURR_W-1:0] RST_FULL_I   = 14'd900;

  typedef enum logic [1:0] {
    REG_CHARGE_V = 2'd0,
    REG_CHARGE_I = 2'd1,
    REG_FULL_V   = 2'd2,
    REG_FULL_I   = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PDO_FIXED    = 2'd0,
    PDO_BATTERY  = 2'd1,
    PDO_VARIABLE = 2'd2,
    PDO_OTHER    = 2'd3
  } pdo_kind_e;

  typedef struct packed {
    logic [VOLT_W-1:0] charge_v;
    logic [CURR_W-1:0] charge_i;
    logic [VOLT_W-1:0] full_v;
    logic [CURR_W-1:0] full_i;
  } cfg_t;

  // one classified PDO as it waits for the back part
  typedef struct packed {
    logic              empty;
    logic              last;
    logic              cmp_en;
    logic [POS_W-1:0]  pos;
    pdo_kind_e         kind;
    logic [VOLT_W-1:0] lo_v;
    logic [VOLT_W-1:0] hi_v;
    logic [VAL_W-1:0]  low10;
    logic [VOLT_W-1:0] req_v;
    logic [CURR_W-1:0] req_i;
    logic [PROD_W-1:0] pwr_prod;
  } pdcs_item_t;

  // request data object with no-suspend set
  function automatic logic [31:0] make_rdo(logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
    return {1'b0, pos, 3'b000, 1'b1, 4'b0000, val, val};
  endfunction

endpackage

// ----- sv/pdcs_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdcs_front: input side of the source capability selector
// Accepts PDO transfers, tracks list position and the charge/full choice,
// decodes the PDO and forms the request product for the back part.
// ----------------------------------------------------------------------------
module pdcs_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pdcs_pkg::cfg_t                 cfg_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [31:0]                    pdo_word_i,
  input  logic                           is_last_i,
  input  logic                           list_empty_i,
  input  logic [pdcs_pkg::PCT_W-1:0]     battery_percent_i,
  input  logic                           queue_full_i,
  output logic                           push_o,
  output pdcs_pkg::pdcs_item_t           item_o
);
  import pdcs_pkg::*;

  logic [POS_W-1:0] index_d, index_q;
  logic             use_full_d, use_full_q;
  logic             use_full_now;
  logic [VOLT_W-1:0] req_v;
  logic [CURR_W-1:0] req_i;

  assign in_ready_o = !queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

  // charge/full choice is sampled on the first item of a list
  always_comb begin
    use_full_now = (index_q == '0) ? (battery_percent_i >= FULL_PERCENT) : use_full_q;
    req_v = use_full_now ? cfg_i.full_v : cfg_i.charge_v;
    req_i = use_full_now ? cfg_i.full_i : cfg_i.charge_i;
  end

  // decode and scale the pdo
  always_comb begin
    item_o.empty    = list_empty_i;
    item_o.last     = is_last_i;
    item_o.cmp_en   = (32'(index_q) < MAX_PDOS);
    item_o.pos      = index_q + POS_W'(1);
    item_o.kind     = pdo_kind_e'(pdo_word_i[31:30]);
    item_o.lo_v     = VOLT_W'(pdo_word_i[19:10]) * VOLT_UNIT_MV;
    item_o.hi_v     = VOLT_W'(pdo_word_i[29:20]) * VOLT_UNIT_MV;
    item_o.low10    = pdo_word_i[9:0];
    item_o.req_v    = req_v;
    item_o.req_i    = req_i;
    item_o.pwr_prod = PROD_W'(req_v) * PROD_W'(req_i);
  end

  // list position, saturating at the list limit
  always_comb begin
    index_d    = index_q;
    use_full_d = use_full_q;
    if (push_o) begin
      if (list_empty_i || is_last_i) begin
        index_d    = '0;
        use_full_d = 1'b0;
      end else begin
        use_full_d = use_full_now;
        if (32'(index_q) < MAX_PDOS) begin
          index_d = index_q + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_q    <= '0;
      use_full_q <= 1'b0;
    end else begin
      index_q    <= index_d;
      use_full_q <= use_full_d;
    end
  end

endmodule

// ----- sv/pdcs_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdcs_queue: short queue between front and back
// Register-based FIFO of classified PDO items so each side stalls on its own.
// ----------------------------------------------------------------------------
module pdcs_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  pdcs_pkg::pdcs_item_t  item_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output pdcs_pkg::pdcs_item_t  head_o
);
  import pdcs_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  pdcs_item_t         mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_d, wr_ptr_q;
  logic [PTR_W-1:0]   rd_ptr_d, rd_ptr_q;
  logic [CNT_W-1:0]   count_d, count_q;

  assign full_o  = (32'(count_q) == QUEUE_DEPTH);
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  // pointer and fill level update
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    count_d  = count_q + CNT_W'(push_i) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // fill level bounded and tracks transfers
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= QUEUE_DEPTH)
    else $error("queue count above depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("pop from empty queue");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("queue count lost a push");

endmodule

// ----- sv/pdcs_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdcs_back: match and result side of the source capability selector
// Compares queued PDOs against the request, keeps the first match of the
// list and drives the result register on the last or empty-list item.
// ----------------------------------------------------------------------------
module pdcs_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          head_valid_i,
  input  pdcs_pkg::pdcs_item_t          head_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          status_o,
  output logic                          found_o,
  output logic [31:0]                   request_object_o,
  output logic [pdcs_pkg::VOLT_W-1:0]   voltage_mv_o
);
  import pdcs_pkg::*;

  logic              match_d, match_q;
  logic [31:0]       req_d, req_q;
  logic [VOLT_W-1:0] volt_d, volt_q;
  logic              out_valid_q;
  logic              status_q, found_q;
  logic [31:0]       rdo_q;
  logic [VOLT_W-1:0] out_volt_q;

  logic              has_result, out_free;
  logic              cur_ok, in_range, pwr_ok, cond, hit;
  logic [PROD_W:0]   pwr_lim;
  logic [52:0]       pwr_mul;
  logic [28:0]       cur_mul;
  logic [VAL_W-1:0]  pwr_val, cur_val, sel_val;

  assign has_result = head_i.empty || head_i.last;
  assign out_free   = !out_valid_q || out_ready_i;
  assign pop_o      = head_valid_i && (!has_result || out_free);

  // pdo compare against the request
  always_comb begin
    cur_ok   = (CURR_W'(head_i.low10) * CURR_UNIT_MA) >= head_i.req_i;
    in_range = (head_i.lo_v <= head_i.req_v) && (head_i.hi_v >= head_i.req_v);
    pwr_lim  = (PROD_W+1)'(head_i.low10) * PWR_LIMIT_STEP + MILLI;
    pwr_ok   = {1'b0, head_i.pwr_prod} < pwr_lim;
    pwr_mul  = 53'(head_i.pwr_prod[PROD_W-1:4]) * 53'(PWR_RECIP);
    pwr_val  = pwr_mul[PWR_SHIFT +: VAL_W];
    cur_mul  = 29'(head_i.req_i) * 29'(CUR_RECIP);
    cur_val  = cur_mul[CUR_SHIFT +: VAL_W];
    unique case (head_i.kind)
      PDO_FIXED: begin
        cond    = (head_i.lo_v == head_i.req_v) && cur_ok;
        sel_val = cur_val;
      end
      PDO_VARIABLE: begin
        cond    = in_range && cur_ok;
        sel_val = cur_val;
      end
      PDO_BATTERY: begin
        cond    = in_range && pwr_ok;
        sel_val = pwr_val;
      end
      default: begin
        cond    = 1'b0;
        sel_val = cur_val;
      end
    endcase
    hit = head_i.cmp_en && !match_q && cond;
  end

  // first match of the list is kept
  always_comb begin
    match_d = match_q;
    req_d   = req_q;
    volt_d  = volt_q;
    if (hit) begin
      match_d = 1'b1;
      req_d   = make_rdo(head_i.pos, sel_val);
      volt_d  = head_i.lo_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
      req_q   <= DEFAULT_RDO;
      volt_q  <= DEFAULT_VOLTAGE_MV;
    end else if (pop_o) begin
      if (has_result) begin
        match_q <= 1'b0;
        req_q   <= DEFAULT_RDO;
        volt_q  <= DEFAULT_VOLTAGE_MV;
      end else begin
        match_q <= match_d;
        req_q   <= req_d;
        volt_q  <= volt_d;
      end
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o && has_result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (pop_o && has_result) begin
      if (head_i.empty) begin
        status_q   <= 1'b1;
        found_q    <= 1'b0;
        rdo_q      <= '0;
        out_volt_q <= '0;
      end else begin
        status_q   <= 1'b0;
        found_q    <= match_d;
        rdo_q      <= req_d;
        out_volt_q <= volt_d;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign found_o          = found_q;
  assign request_object_o = rdo_q;
  assign voltage_mv_o     = out_volt_q;

  // list state returns to defaults after any result
  a_clear_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && has_result |=> !match_q && req_q == DEFAULT_RDO)
    else $error("list state not cleared after result");

  a_match_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    match_q && !(pop_o && has_result) |=> $stable(req_q) && $stable(volt_q))
    else $error("kept match overwritten");

  a_error_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q |-> !found_q && rdo_q == '0)
    else $error("error result carries match data");

endmodule

// ----- sv/pd_source_cap_select.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pd_source_cap_select: sink-side USB PD source capability selection
// Picks the first source PDO of a list that meets the requested voltage and
// current (or power) and returns the request data object on the last PDO.
//
//  channel   dir  handshake           contents
//  s_axis    in   tvalid/tready       one source PDO, last mark, empty flag
//  m_axis    out  tvalid/tready       status, found, request object, voltage
//  cfg       in   cfg_we_i            request register write, no read-back
//
// One PDO transfer is accepted every cycle while the queue has room; result
// tvalid rises after the last PDO passes a queue entry, then the result register.
// A two-entry queue sits between the decode/multiply front and the compare
// back, so plain PDOs keep flowing while a result waits on m_axis.
// s_axis tready falls while both queue entries are held and returns in the cycle
// after the back takes an entry.
// Reset clears the list state and loads the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module pd_source_cap_select (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // register write port
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_addr_i,
  input  logic [15:0]                       cfg_wdata_i,
  // pdo input stream
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [pdcs_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,  // pdo_word, battery_percent
  input  logic                              s_axis_tlast_i,
  input  logic                              s_axis_tuser_i,  // list_empty
  // result stream
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [pdcs_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,  // found, request_object, voltage_mv
  output logic                              m_axis_tuser_o   // status
);
  import pdcs_pkg::*;

  cfg_t              cfg_q;
  logic              push, pop, queue_full, head_valid;
  pdcs_item_t        item, head;
  logic              found;
  logic [31:0]       request_object;
  logic [VOLT_W-1:0] voltage_mv;

  // request registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.charge_v <= RST_CHARGE_V;
      cfg_q.charge_i <= RST_CHARGE_I;
      cfg_q.full_v   <= RST_FULL_V;
      cfg_q.full_i   <= RST_FULL_I;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_CHARGE_V: cfg_q.charge_v <= cfg_wdata_i;
        REG_CHARGE_I: cfg_q.charge_i <= cfg_wdata_i[CURR_W-1:0];
        REG_FULL_V:   cfg_q.full_v   <= cfg_wdata_i;
        REG_FULL_I:   cfg_q.full_i   <= cfg_wdata_i[CURR_W-1:0];
        default:      cfg_q.full_i   <= cfg_q.full_i;
      endcase
    end
  end

  pdcs_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .in_valid_i        (s_axis_tvalid_i),
    .in_ready_o        (s_axis_tready_o),
    .pdo_word_i        (s_axis_tdata_i[31:0]),
    .is_last_i         (s_axis_tlast_i),
    .list_empty_i      (s_axis_tuser_i),
    .battery_percent_i (s_axis_tdata_i[32 +: PCT_W]),
    .queue_full_i      (queue_full),
    .push_o            (push),
    .item_o            (item)
  );

  pdcs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (item),
    .full_o  (queue_full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .head_o  (head)
  );

  pdcs_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_valid_i     (head_valid),
    .head_i           (head),
    .pop_o            (pop),
    .out_valid_o      (m_axis_tvalid_o),
    .out_ready_i      (m_axis_tready_i),
    .status_o         (m_axis_tuser_o),
    .found_o          (found),
    .request_object_o (request_object),
    .voltage_mv_o     (voltage_mv)
  );

  // result packing, low bits first
  assign m_axis_tdata_o = {7'd0, voltage_mv, request_object, found};

endmodule
